// ===== hdl/gce_pkg.sv =====
// gce_pkg: shared sizes, codes and types of the glyph cache
// no dependencies; used by every module of the cache except the generic ram

package gce_pkg;

   // number of cache entries, 2 to 256 (the slot output is SLOT_OUT_W = 8 bits wide)
   localparam int ENTRIES  = 256;
   localparam int SLOT_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   // cells are chained in groups; the priority chain runs inside a group
   localparam int GROUP    = 8;
   localparam int GRP_W    = $clog2(GROUP);
   localparam int GROUPS   = (ENTRIES + GROUP - 1) / GROUP;
   localparam int GIDX_W   = (GROUPS > 1) ? $clog2(GROUPS) : 1;
   localparam int PAD_CELLS = GROUPS * GROUP;

   // field widths
   localparam int CHAR_W   = 21;
   localparam int SIZE_W   = 8;
   localparam int FONT_W   = 2;
   localparam int KEY_W    = CHAR_W + SIZE_W + FONT_W;
   localparam int BYTE_W   = 8;
   localparam int GNUM_W   = 16;
   localparam int META_W   = 5 * BYTE_W + GNUM_W;
   localparam int HANDLE_W = 32;
   localparam int RAM_W    = META_W + HANDLE_W;
   localparam int SLOT_OUT_W = 8;

   // operation codes
   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_INSERT = 1'b1;

   // key broadcast to every cell; write set only for the cell at the replacement pointer
   typedef struct packed {
      logic             write;
      logic [KEY_W-1:0] key;
   } cell_ctl_type;

   // what a cell shows to the rest of the row
   typedef struct packed {
      logic valid;
      logic match;
      logic found;
      logic first;
   } cell_stat_type;

   // registered result of one group
   typedef struct packed {
      logic             found;
      logic [GRP_W-1:0] idx;
   } grp_stat_type;

endpackage

// ===== hdl/gce_ram.sv =====
// gce_ram: generic single write, single read ram with registered read
// no dependencies

module gce_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/gce_cell.sv =====
// gce_cell: one cache entry tag cell (valid bit, key, registered compare)
// depends on gce_pkg; hands its found flag on to the next cell of its group

module gce_cell
   import gce_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_ctl_type  ctl,
   input  logic          prior_found,
   output cell_stat_type stat
);

   logic             valid_ff, valid_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic             match_ff, match_in;

   always_comb begin
      valid_in = valid_ff | ctl.write;
      key_in   = ctl.write ? ctl.key : key_ff;
      match_in = valid_ff && (key_ff == ctl.key);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      match_ff <= match_in;
   end

   // lowest matching cell of the group claims the hit
   assign stat.valid = valid_ff;
   assign stat.match = match_ff;
   assign stat.found = prior_found | match_ff;
   assign stat.first = match_ff & ~prior_found;

endmodule

// ===== hdl/gce_group.sv =====
// gce_group: encodes the first-match flags of one group of cells
// depends on gce_pkg

module gce_group
   import gce_pkg::*;
(
   input  logic             clock,
   input  logic [GROUP-1:0] first,
   output grp_stat_type     stat
);

   grp_stat_type stat_ff, stat_in;

   // first is one-hot or zero, so an or of the selected positions is enough
   always_comb begin
      stat_in.found = |first;
      stat_in.idx   = '0;
      for (int c = 0; c < GROUP; c++) begin
         if (first[c]) begin
            stat_in.idx = stat_in.idx | GRP_W'(c);
         end
      end
   end

   always_ff @(posedge clock) begin
      stat_ff <= stat_in;
   end

   assign stat = stat_ff;

endmodule

// ===== hdl/glyph_cache_fifo_top.sv =====
// glyph_cache_fifo_top: fully associative glyph cache with round-robin replacement
// depends on gce_pkg, gce_cell, gce_group and gce_ram

// A lookup transaction compares its key (code point, size, font) against every valid
// entry and returns the lowest matching slot with its metrics and bitmap handle; an
// insert transaction writes the entry at the round-robin pointer and reports the
// handle of any valid entry it replaced so that the bitmap can be freed. Tags live in
// a row of cells, one per entry, that compare in parallel; a priority chain runs
// through each group of eight cells, the group results are registered and then the
// first group is picked. Metrics and handles sit in one ram with a registered read.
// One transaction is in flight at a time: a lookup goes from acceptance to the result
// register through compare, group encode, group select, ram read and result; an
// insert goes through ram read of the old handle, then result and write. The next
// request is taken while a result still waits on rsp_stall. Reset clears all valid
// bits at once; no clearing pass is needed.

module glyph_cache_fifo_top
   import gce_pkg::*;
(
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_op,
   input  logic [CHAR_W-1:0]   req_character,
   input  logic [SIZE_W-1:0]   req_point_size,
   input  logic [FONT_W-1:0]   req_font_id,
   input  logic [BYTE_W-1:0]   req_glyph_width,
   input  logic [BYTE_W-1:0]   req_glyph_height,
   input  logic signed [BYTE_W-1:0] req_x_offset,
   input  logic signed [BYTE_W-1:0] req_y_offset,
   input  logic [BYTE_W-1:0]   req_advance,
   input  logic [GNUM_W-1:0]   req_glyph_number,
   input  logic [HANDLE_W-1:0] req_bitmap_handle,

   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_hit,
   output logic [SLOT_OUT_W-1:0] rsp_slot,
   output logic [BYTE_W-1:0]   rsp_out_width,
   output logic [BYTE_W-1:0]   rsp_out_height,
   output logic signed [BYTE_W-1:0] rsp_out_x_offset,
   output logic signed [BYTE_W-1:0] rsp_out_y_offset,
   output logic [BYTE_W-1:0]   rsp_out_advance,
   output logic [GNUM_W-1:0]   rsp_out_glyph_number,
   output logic [HANDLE_W-1:0] rsp_out_bitmap_handle,
   output logic                rsp_evicted_valid,
   output logic [HANDLE_W-1:0] rsp_evicted_handle
);

   // sequencer states, one-hot
   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_CMP    = 6'b000010,
      S_GRP    = 6'b000100,
      S_SEL    = 6'b001000,
      S_READ   = 6'b010000,
      S_FIN    = 6'b100000
   } state_type;

   localparam state_type S_INS_RD = S_READ;

   state_type state_ff, state_in;

   // captured request
   logic                op_ff, op_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [META_W-1:0]   meta_ff, meta_in;
   logic [HANDLE_W-1:0] handle_ff, handle_in;

   // lookup result and replacement state
   logic                hit_ff, hit_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [SLOT_W-1:0]   ptr_ff, ptr_in;
   logic                evict_v_ff, evict_v_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_hit_ff;
   logic [SLOT_OUT_W-1:0] rsp_slot_ff;
   logic [META_W-1:0]   rsp_meta_ff;
   logic [HANDLE_W-1:0] rsp_handle_ff;
   logic                rsp_ev_valid_ff;
   logic [HANDLE_W-1:0] rsp_ev_handle_ff;

   logic                accept;
   logic                load;
   logic                ins_load;

   // cell row
   cell_ctl_type        cell_ctl [PAD_CELLS];
   cell_stat_type       cell_stat [PAD_CELLS];
   logic [PAD_CELLS-1:0] prior_vec;
   logic [PAD_CELLS-1:0] found_vec;
   logic [PAD_CELLS-1:0] first_vec;
   logic [ENTRIES-1:0]   valid_vec;
   logic [ENTRIES-1:0]   match_vec;
   grp_stat_type         grp_stat [GROUPS];

   // group select
   logic                sel_hit;
   logic [GIDX_W-1:0]   sel_gidx;
   logic [GRP_W-1:0]    sel_idx;

   // entry ram
   logic                ram_rd_en;
   logic [SLOT_W-1:0]   ram_rd_addr;
   logic [RAM_W-1:0]    ram_rd_data;
   logic [RAM_W-1:0]    ram_wr_data;

   // handshake
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && (state_ff == S_IDLE);
   // result slot is free or being emptied this cycle
   assign load      = (state_ff == S_FIN) && (!rsp_valid_ff || !rsp_stall);
   assign ins_load  = load && (op_ff == OP_INSERT);

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = (req_op == OP_INSERT) ? S_INS_RD : S_CMP;
            end
         end
         S_CMP:  state_in = S_GRP;
         S_GRP:  state_in = S_SEL;
         S_SEL:  state_in = S_READ;
         S_READ: state_in = S_FIN;
         S_FIN: begin
            if (load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // request capture
   always_comb begin
      op_in     = op_ff;
      key_in    = key_ff;
      meta_in   = meta_ff;
      handle_in = handle_ff;
      if (accept) begin
         op_in     = req_op;
         key_in    = {req_font_id, req_point_size, req_character};
         meta_in   = {req_glyph_number, req_advance, req_y_offset, req_x_offset,
                      req_glyph_height, req_glyph_width};
         handle_in = req_bitmap_handle;
      end
   end

   // cell row: tags compared in parallel, priority chained within each group
   for (genvar i = 0; i < PAD_CELLS; i++) begin : g_cell
      if (i % GROUP == 0) begin : g_head
         assign prior_vec[i] = 1'b0;
      end else begin : g_link
         assign prior_vec[i] = found_vec[i-1];
      end

      if (i < ENTRIES) begin : g_real
         assign cell_ctl[i].write = ins_load && (ptr_ff == SLOT_W'(i));
         assign cell_ctl[i].key   = key_ff;

         gce_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctl         (cell_ctl[i]),
            .prior_found (prior_vec[i]),
            .stat        (cell_stat[i])
         );

         assign valid_vec[i] = cell_stat[i].valid;
         assign match_vec[i] = cell_stat[i].match;
         assign found_vec[i] = cell_stat[i].found;
         assign first_vec[i] = cell_stat[i].first;
      end else begin : g_pad
         // padding beyond the last entry never matches
         assign cell_ctl[i]  = '0;
         assign cell_stat[i] = '0;
         assign found_vec[i] = prior_vec[i] | cell_stat[i].match;
         assign first_vec[i] = cell_stat[i].first | cell_ctl[i].write;
      end
   end

   for (genvar g = 0; g < GROUPS; g++) begin : g_grp
      gce_group u_group (
         .clock (clock),
         .first (first_vec[g*GROUP +: GROUP]),
         .stat  (grp_stat[g])
      );
   end

   // lowest group with a match wins
   always_comb begin
      sel_hit  = 1'b0;
      sel_gidx = '0;
      sel_idx  = '0;
      for (int g = GROUPS - 1; g >= 0; g--) begin
         if (grp_stat[g].found) begin
            sel_hit  = 1'b1;
            sel_gidx = GIDX_W'(g);
            sel_idx  = grp_stat[g].idx;
         end
      end
   end

   always_comb begin
      hit_in  = hit_ff;
      slot_in = slot_ff;
      if (state_ff == S_SEL) begin
         hit_in  = sel_hit;
         slot_in = SLOT_W'({sel_gidx, sel_idx});
      end
   end

   // replacement pointer wraps after the last entry
   always_comb begin
      ptr_in = ptr_ff;
      if (ins_load) begin
         ptr_in = (ptr_ff == SLOT_W'(ENTRIES - 1)) ? '0 : ptr_ff + SLOT_W'(1);
      end
   end

   // valid bit of the slot about to be replaced
   always_comb begin
      evict_v_in = evict_v_ff;
      if ((state_ff == S_INS_RD) && (op_ff == OP_INSERT)) begin
         evict_v_in = valid_vec[ptr_ff];
      end
   end

   // entry ram: metrics in the low bits, bitmap handle on top
   assign ram_rd_en   = (state_ff == S_READ);
   assign ram_rd_addr = (op_ff == OP_INSERT) ? ptr_ff : slot_ff;
   assign ram_wr_data = {handle_ff, meta_ff};

   gce_ram #(
      .WIDTH (RAM_W),
      .DEPTH (ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ins_load),
      .wr_addr (ptr_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      key_ff     <= key_in;
      meta_ff    <= meta_in;
      handle_ff  <= handle_in;
      hit_ff     <= hit_in;
      slot_ff    <= slot_in;
      evict_v_ff <= evict_v_in;
      if (load) begin
         if (op_ff == OP_INSERT) begin
            rsp_hit_ff       <= 1'b0;
            rsp_slot_ff      <= SLOT_OUT_W'(ptr_ff);
            rsp_meta_ff      <= '0;
            rsp_handle_ff    <= '0;
            rsp_ev_valid_ff  <= evict_v_ff;
            rsp_ev_handle_ff <= evict_v_ff ? ram_rd_data[RAM_W-1:META_W] : '0;
         end else begin
            rsp_hit_ff       <= hit_ff;
            rsp_slot_ff      <= hit_ff ? SLOT_OUT_W'(slot_ff) : '0;
            rsp_meta_ff      <= hit_ff ? ram_rd_data[META_W-1:0] : '0;
            rsp_handle_ff    <= hit_ff ? ram_rd_data[RAM_W-1:META_W] : '0;
            rsp_ev_valid_ff  <= 1'b0;
            rsp_ev_handle_ff <= '0;
         end
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_hit               = rsp_hit_ff;
   assign rsp_slot              = rsp_slot_ff;
   assign rsp_out_width         = rsp_meta_ff[BYTE_W-1:0];
   assign rsp_out_height        = rsp_meta_ff[2*BYTE_W-1:BYTE_W];
   assign rsp_out_x_offset      = rsp_meta_ff[3*BYTE_W-1:2*BYTE_W];
   assign rsp_out_y_offset      = rsp_meta_ff[4*BYTE_W-1:3*BYTE_W];
   assign rsp_out_advance       = rsp_meta_ff[5*BYTE_W-1:4*BYTE_W];
   assign rsp_out_glyph_number  = rsp_meta_ff[META_W-1:5*BYTE_W];
   assign rsp_out_bitmap_handle = rsp_handle_ff;
   assign rsp_evicted_valid     = rsp_ev_valid_ff;
   assign rsp_evicted_handle    = rsp_ev_handle_ff;

`ifndef SYNTHESIS
   // a selected slot really matched in the compare stage
   a_hit_slot_matches: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) && (op_ff == OP_LOOKUP) && hit_ff |-> match_vec[slot_ff])
      else $error("lookup hit on a slot that did not match");

   // a written entry is valid afterwards
   a_insert_sets_valid: assert property (@(posedge clock) disable iff (reset)
      ins_load |=> valid_vec[$past(ptr_ff)])
      else $error("inserted entry not valid");

   // the pointer moves only on an insert
   a_ptr_step: assert property (@(posedge clock) disable iff (reset)
      !ins_load |=> $stable(ptr_ff))
      else $error("replacement pointer moved without an insert");

   // a hit never comes with an eviction
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_hit_ff |-> !rsp_ev_valid_ff)
      else $error("hit and eviction in one transaction");
`endif

endmodule
